[src/sust_pkg.sv]
// Shared types, sizes and codes for the sorted unique set table.
// Used by sust_seq, sorted_unique_set_table and sust_chk; depends on nothing.
package sust_pkg;

    localparam int CAPACITY = 16;
    localparam int VALUE_W  = 32;

    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int FIELD_W  = 32;
    localparam int RANK_W   = 4;
    localparam int FUNC_W   = 2;
    localparam int STAT_W   = 2;
    localparam int ECOUNT_W = 5;
    localparam int CMP_W    = (COUNT_W > RANK_W) ? COUNT_W : RANK_W;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_GET    = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_DUP   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    typedef logic signed [VALUE_W-1:0] t_value;

    // Finish report from the sequencer to the top level.
    typedef struct packed {
        logic              valid;
        logic [STAT_W-1:0] status;
        t_value            data;
        logic              inc;
        logic              dec;
    } t_fin;

    // Entry RAM access from the sequencer.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_value            wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    // Low bits of the field, sign-extended to the stored width.
    function automatic t_value to_store(input logic signed [FIELD_W-1:0] v);
        logic signed [63:0] wide;
        wide = 64'(v);
        return wide[VALUE_W-1:0];
    endfunction

    // Stored entry seen on the 32-bit result port.
    function automatic logic signed [FIELD_W-1:0] to_port(input t_value v);
        logic signed [63:0] wide;
        wide = 64'(v);
        return wide[FIELD_W-1:0];
    endfunction

endpackage

[src/sust_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module sust_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/sust_seq.sv]
// Operation sequencer: scan, shift and access steps on the entry RAM.
// Depends on sust_pkg.
module sust_seq (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [sust_pkg::FUNC_W-1:0]         i_func,
    input  logic signed [sust_pkg::FIELD_W-1:0] i_value,
    input  logic [sust_pkg::RANK_W-1:0]         i_rank,
    input  logic [sust_pkg::COUNT_W-1:0]        i_count,
    input  sust_pkg::t_value                    i_rdata,
    output sust_pkg::t_ram_req                  o_req,
    output sust_pkg::t_fin                      o_fin,
    output logic                                o_busy
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN_RD  = 4'd1;
    localparam logic [3:0] S_SCAN_CMP = 4'd2;
    localparam logic [3:0] S_UP_RD    = 4'd3;
    localparam logic [3:0] S_UP_WR    = 4'd4;
    localparam logic [3:0] S_PUT      = 4'd5;
    localparam logic [3:0] S_DN_RD    = 4'd6;
    localparam logic [3:0] S_DN_WR    = 4'd7;
    localparam logic [3:0] S_GET      = 4'd8;

    localparam int CW = sust_pkg::COUNT_W;
    localparam int AW = sust_pkg::ADDR_W;

    logic [3:0]       r_state, n_state;
    sust_pkg::t_value r_val, n_val;
    logic [CW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_pos, n_pos;

    logic [CW-1:0]    w_next;
    logic [CW-1:0]    w_prev;
    logic [CW-1:0]    w_ins;
    logic             w_range;

    assign w_next  = r_idx + CW'(1);
    assign w_prev  = r_idx - CW'(1);
    assign w_range = sust_pkg::CMP_W'(i_rank) >= sust_pkg::CMP_W'(i_count);
    assign w_ins   = (i_rdata < r_val) ? w_next : r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_val <= n_val;
        r_idx <= n_idx;
        r_pos <= n_pos;
    end

    // Reads and writes alternate in every shift loop, and a shift never reads the
    // slot it has just written, so no same-entry overlap reaches the RAM.
    always_comb begin
        n_state = r_state;
        n_val   = r_val;
        n_idx   = r_idx;
        n_pos   = r_pos;
        o_req   = '0;
        o_fin   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_func)
                        sust_pkg::FUNC_INSERT: begin
                            n_val = sust_pkg::to_store(i_value);
                            n_idx = '0;
                            n_pos = '0;
                            if (i_count == '0) begin
                                n_state = S_PUT;
                            end else begin
                                n_state = S_SCAN_RD;
                            end
                        end
                        sust_pkg::FUNC_REMOVE: begin
                            if (w_range) begin
                                o_fin.valid  = 1'b1;
                                o_fin.status = sust_pkg::ST_RANGE;
                            end else begin
                                n_idx   = CW'(i_rank);
                                n_state = S_DN_RD;
                            end
                        end
                        sust_pkg::FUNC_GET: begin
                            if (w_range) begin
                                o_fin.valid  = 1'b1;
                                o_fin.status = sust_pkg::ST_RANGE;
                            end else begin
                                o_req.raddr = AW'(i_rank);
                                n_state     = S_GET;
                            end
                        end
                        default: begin
                            o_fin.valid  = 1'b1;
                            o_fin.status = sust_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN_RD: begin
                o_req.raddr = r_idx[AW-1:0];
                n_state     = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (i_rdata == r_val) begin
                    o_fin.valid  = 1'b1;
                    o_fin.status = sust_pkg::ST_DUP;
                    n_state      = S_IDLE;
                end else if (i_rdata < r_val && w_next < i_count) begin
                    n_idx   = w_next;
                    n_state = S_SCAN_RD;
                end else if (i_count >= CW'(sust_pkg::CAPACITY)) begin
                    o_fin.valid  = 1'b1;
                    o_fin.status = sust_pkg::ST_FULL;
                    n_state      = S_IDLE;
                end else begin
                    n_pos = w_ins;
                    n_idx = i_count;
                    if (i_count > w_ins) begin
                        n_state = S_UP_RD;
                    end else begin
                        n_state = S_PUT;
                    end
                end
            end
            S_UP_RD: begin
                o_req.raddr = w_prev[AW-1:0];
                n_state     = S_UP_WR;
            end
            S_UP_WR: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_idx[AW-1:0];
                o_req.wdata = i_rdata;
                n_idx       = w_prev;
                if (w_prev > r_pos) begin
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                o_req.we     = 1'b1;
                o_req.waddr  = r_pos[AW-1:0];
                o_req.wdata  = r_val;
                o_fin.valid  = 1'b1;
                o_fin.status = sust_pkg::ST_OK;
                o_fin.inc    = 1'b1;
                n_state      = S_IDLE;
            end
            S_DN_RD: begin
                if (w_next < i_count) begin
                    o_req.raddr = w_next[AW-1:0];
                    n_state     = S_DN_WR;
                end else begin
                    o_fin.valid  = 1'b1;
                    o_fin.status = sust_pkg::ST_OK;
                    o_fin.dec    = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_DN_WR: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_idx[AW-1:0];
                o_req.wdata = i_rdata;
                n_idx       = w_next;
                n_state     = S_DN_RD;
            end
            S_GET: begin
                o_fin.valid  = 1'b1;
                o_fin.status = sust_pkg::ST_OK;
                o_fin.data   = i_rdata;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

[src/sorted_unique_set_table.sv]
// Top level of the sorted unique set table: entry RAM, sequencer, count and
// result registers. Depends on sust_pkg, sust_ram and sust_seq.
//
// Usage
//   Command channel: drive i_func, i_value and i_rank with start high; the
//   beat is taken at a rising edge where busy is low. busy stays high until
//   the operation has finished.
//   Result channel: o_valid marks a single-cycle beat carrying o_status,
//   o_read_value and o_entry_count. The receiver cannot hold it off; the
//   next command may be taken in the cycle that shows the result.
//   Steps, n = count:
//     out-of-range, unused func: reported straight from idle
//     get: one read of the entry at the rank
//     remove at rank r: the n-1-r entries above r each shift down one slot
//     insert at position p: a scan from slot 0 up, then the n-p entries from p
//     up each shift up one slot, then the new value is written at p; duplicate
//     or full stops after the scan; insert into empty writes at once.
//   The registered read of the entry RAM sets the pace: every scan step and
//   every shift step is a read followed by a compare or a write.
//   Reset clears the entry count and the sequencer; the RAM contents are
//   not cleared, only slots below the count are ever read.
module sorted_unique_set_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [sust_pkg::FUNC_W-1:0]         i_func,
    input  logic signed [sust_pkg::FIELD_W-1:0] i_value,
    input  logic [sust_pkg::RANK_W-1:0]         i_rank,
    output logic                                o_valid,
    output logic [sust_pkg::STAT_W-1:0]         o_status,
    output logic signed [sust_pkg::FIELD_W-1:0] o_read_value,
    output logic [sust_pkg::ECOUNT_W-1:0]       o_entry_count
);

    localparam int CW = sust_pkg::COUNT_W;

    logic [CW-1:0]               r_count;
    logic                        r_valid;
    logic [sust_pkg::STAT_W-1:0] r_status;
    sust_pkg::t_value            r_rdata;

    sust_pkg::t_ram_req w_req;
    sust_pkg::t_fin     w_fin;
    sust_pkg::t_value   w_rdata;
    logic               w_busy;

    sust_ram #(
        .WIDTH (sust_pkg::VALUE_W),
        .DEPTH (sust_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_req.we),
        .i_waddr (w_req.waddr),
        .i_wdata (w_req.wdata),
        .i_raddr (w_req.raddr),
        .o_rdata (w_rdata)
    );

    sust_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_func),
        .i_value (i_value),
        .i_rank  (i_rank),
        .i_count (r_count),
        .i_rdata (w_rdata),
        .o_req   (w_req),
        .o_fin   (w_fin),
        .o_busy  (w_busy)
    );

    // Advance the count and capture the result beat when the sequencer
    // finishes; the strobe is registered from the finish report.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_fin.valid;
            if (w_fin.valid && w_fin.inc) begin
                r_count <= r_count + CW'(1);
            end else if (w_fin.valid && w_fin.dec) begin
                r_count <= r_count - CW'(1);
            end
        end
        if (w_fin.valid) begin
            r_status <= w_fin.status;
            r_rdata  <= w_fin.data;
        end
    end

    assign busy          = w_busy;
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_read_value  = sust_pkg::to_port(r_rdata);
    assign o_entry_count = sust_pkg::ECOUNT_W'(r_count);

endmodule

[src/sust_chk.sv]
// Port-level checker for the sorted unique set table, bound to the top.
// Depends on sust_pkg.
module sust_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                o_valid,
    input logic [sust_pkg::STAT_W-1:0]         o_status,
    input logic signed [sust_pkg::FIELD_W-1:0] o_read_value,
    input logic [sust_pkg::ECOUNT_W-1:0]       o_entry_count
);

    // An accepted command either starts work or reports in the next cycle.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_valid)
        else $error("accepted command neither busy nor reported");

    // A result beat is only shown once the sequencer is idle again.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    // A failed operation leaves the count alone.
    a_fail_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != sust_pkg::ST_OK |->
            o_entry_count == $past(o_entry_count))
        else $error("count moved on failed operation");

    // Read data is zero unless the beat reports success.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != sust_pkg::ST_OK |-> o_read_value == '0)
        else $error("nonzero read value on failed operation");

    // The count never passes the capacity on a result beat.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> 32'(o_entry_count) <= 32'(sust_pkg::CAPACITY))
        else $error("entry count beyond capacity");

endmodule

bind sorted_unique_set_table sust_chk u_sust_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_status      (o_status),
    .o_read_value  (o_read_value),
    .o_entry_count (o_entry_count)
);
